>>> src/ibs_pkg.sv
// types, constants and the microprogram of the i2c master bit sequencer
// no dependencies; used by the core, the line checker and the testbench
package ibs_pkg;

	// command opcodes
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_SACK  = 3'd4;
	localparam logic [2:0] OP_RACK  = 3'd5;

	// sda source of a micro step
	localparam logic [2:0] SDA_KEEP = 3'd0;
	localparam logic [2:0] SDA_ONE  = 3'd1;
	localparam logic [2:0] SDA_ZERO = 3'd2;
	localparam logic [2:0] SDA_TX   = 3'd3;
	localparam logic [2:0] SDA_ACK  = 3'd4;

	// scl action of a micro step
	localparam logic [1:0] SCL_KEEP = 2'd0;
	localparam logic [1:0] SCL_ONE  = 2'd1;
	localparam logic [1:0] SCL_ZERO = 2'd2;

	// read value source on the final step
	localparam logic [1:0] RV_NONE = 2'd0;
	localparam logic [1:0] RV_BYTE = 2'd1;
	localparam logic [1:0] RV_ACK  = 2'd2;

	localparam int unsigned PC_W = 5;
	localparam logic [2:0] BIT_LAST = 3'd7;
	localparam logic [15:0] HOLD_RESET = 16'd720;

	// microprogram entry points
	localparam logic [PC_W-1:0] PC_START = 5'd0;
	localparam logic [PC_W-1:0] PC_STOP  = 5'd4;
	localparam logic [PC_W-1:0] PC_WRITE = 5'd7;
	localparam logic [PC_W-1:0] PC_READ  = 5'd10;
	localparam logic [PC_W-1:0] PC_SACK  = 5'd13;
	localparam logic [PC_W-1:0] PC_RACK  = 5'd16;

	typedef struct packed {
		logic [2:0]      sda_sel;
		logic [1:0]      scl_sel;
		logic            fin;
		logic            loop;
		logic [1:0]      rv_sel;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t mk(input logic [2:0] sda_sel, input logic [1:0] scl_sel,
			input logic fin, input logic loop, input logic [1:0] rv_sel,
			input logic [PC_W-1:0] target);
		ctrl_word_t w;
		w.sda_sel = sda_sel;
		w.scl_sel = scl_sel;
		w.fin     = fin;
		w.loop    = loop;
		w.rv_sel  = rv_sel;
		w.target  = target;
		return w;
	endfunction

	// control store
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		unique case (pc)
			// start
			5'd0:    w = mk(SDA_ONE,  SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_START);
			5'd1:    w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_START);
			5'd2:    w = mk(SDA_ZERO, SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_START);
			5'd3:    w = mk(SDA_KEEP, SCL_ZERO, 1'b1, 1'b0, RV_NONE, PC_START);
			// stop
			5'd4:    w = mk(SDA_ZERO, SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_STOP);
			5'd5:    w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_STOP);
			5'd6:    w = mk(SDA_ONE,  SCL_KEEP, 1'b1, 1'b0, RV_NONE, PC_STOP);
			// write byte, one bit per pass
			5'd7:    w = mk(SDA_TX,   SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_WRITE);
			5'd8:    w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_WRITE);
			5'd9:    w = mk(SDA_KEEP, SCL_ZERO, 1'b0, 1'b1, RV_NONE, PC_WRITE);
			// read byte
			5'd10:   w = mk(SDA_ONE,  SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_READ);
			5'd11:   w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_READ);
			5'd12:   w = mk(SDA_KEEP, SCL_ZERO, 1'b0, 1'b1, RV_BYTE, 5'd11);
			// send ack
			5'd13:   w = mk(SDA_ACK,  SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_SACK);
			5'd14:   w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_SACK);
			5'd15:   w = mk(SDA_KEEP, SCL_ZERO, 1'b1, 1'b0, RV_NONE, PC_SACK);
			// read ack
			5'd16:   w = mk(SDA_ONE,  SCL_KEEP, 1'b0, 1'b0, RV_NONE, PC_RACK);
			5'd17:   w = mk(SDA_KEEP, SCL_ONE,  1'b0, 1'b0, RV_NONE, PC_RACK);
			5'd18:   w = mk(SDA_KEEP, SCL_ZERO, 1'b1, 1'b0, RV_ACK,  PC_RACK);
			default: w = mk(SDA_KEEP, SCL_KEEP, 1'b1, 1'b0, RV_NONE, PC_START);
		endcase
		return w;
	endfunction

endpackage

>>> src/ibs_if.sv
// channel interfaces of the i2c master bit sequencer: command in, line step out
// depends on nothing but plain logic types
interface ibs_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] tx_byte;
	logic       ack_to_send;
	logic [7:0] bus_sda_bits;

	modport source (output valid, output opcode, output tx_byte, output ack_to_send,
		output bus_sda_bits, input ready);
	modport sink (input valid, input opcode, input tx_byte, input ack_to_send,
		input bus_sda_bits, output ready);
endinterface

interface ibs_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] read_value;
	logic       last;

	modport source (output valid, output scl_level, output sda_level, output read_value,
		output last, input ready);
	modport sink (input valid, input scl_level, input sda_level, input read_value,
		input last, output ready);
endinterface

>>> src/i2c_master_bit_sequencer_core.sv
// i2c master bit sequencer core: microcoded expansion of commands into scl/sda line steps
// depends on ibs_pkg (control store, codes) and ibs_if.sv (channel interfaces)
//
// usage
// - cmd channel: one item is one i2c master command (start, stop, write byte, read byte,
//   send ack, read ack); taken only while no command is in progress
// - res channel: one item per line step, carrying the scl/sda levels after the step,
//   the read value on the final step and a last flag
// - cfg_we/cfg_wdata: write of hold_cycles, the cycles each line state is held
//   (0 behaves as 1); write only while idle
// - the first step is offered on res once the command is registered and the output
//   register is free; a command of n steps (4, 3, 24, 17, 3 or 3) is not followed
//   by the next one until its last line state has been held, and a stalled receiver
//   delays it further; the hold counter between steps sets the pace
// - opcodes 6 and 7 are taken and dropped without any result
// - reset: both lines released high, sequencer idle, hold_cycles back to 720
// - a stalled receiver holds the sequencer back: the next step waits in the control
//   store until the output register frees, so no step is lost
module i2c_master_bit_sequencer_core (
	input  logic              clk,
	input  logic              arst_n,
	ibs_cmd_if.sink           cmd,
	ibs_res_if.source         res,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);

	// configuration
	logic [15:0] hold_cycles_q;

	// sequencer state
	logic                         busy_q;
	logic                         fin_q;     // final step sent, waiting out its hold
	logic [ibs_pkg::PC_W-1:0]     pc_q;      // micro step counter
	logic [2:0]                   bit_q;     // bit index inside a byte loop
	logic [15:0]                  wait_q;    // hold countdown
	logic [7:0]                   tx_q;      // transmit shift register, msb out first
	logic                         ack_q;
	logic [7:0]                   bus_q;     // sampled sda levels
	logic                         scl_q;
	logic                         sda_q;

	// output register
	logic       res_valid_q;
	logic       res_scl_q;
	logic       res_sda_q;
	logic [7:0] res_rv_q;
	logic       res_last_q;

	ibs_pkg::ctrl_word_t       cw;
	logic                      emit_go;
	logic                      loop_back;
	logic                      step_last;
	logic                      scl_nxt;
	logic                      sda_nxt;
	logic [7:0]                rv_nxt;
	logic [ibs_pkg::PC_W-1:0]  pc_nxt;
	logic [ibs_pkg::PC_W-1:0]  entry_pc;
	logic                      entry_ok;
	logic                      cmd_take;
	logic [15:0]               hold_load;

	// entry point of each command's micro routine
	always_comb begin
		entry_ok = 1'b1;
		unique case (cmd.opcode)
			ibs_pkg::OP_START: entry_pc = ibs_pkg::PC_START;
			ibs_pkg::OP_STOP:  entry_pc = ibs_pkg::PC_STOP;
			ibs_pkg::OP_WRITE: entry_pc = ibs_pkg::PC_WRITE;
			ibs_pkg::OP_READ:  entry_pc = ibs_pkg::PC_READ;
			ibs_pkg::OP_SACK:  entry_pc = ibs_pkg::PC_SACK;
			ibs_pkg::OP_RACK:  entry_pc = ibs_pkg::PC_RACK;
			default: begin
				entry_pc = ibs_pkg::PC_START;
				entry_ok = 1'b0;
			end
		endcase
	end

	assign cmd.ready = !busy_q;
	assign cmd_take  = cmd.valid && !busy_q;

	// current control word drives the datapath
	assign cw        = ibs_pkg::ucode(pc_q);
	assign loop_back = cw.loop && (bit_q != ibs_pkg::BIT_LAST);
	assign step_last = cw.fin || (cw.loop && (bit_q == ibs_pkg::BIT_LAST));
	assign pc_nxt    = loop_back ? cw.target : pc_q + 1'b1;
	assign emit_go   = busy_q && !fin_q && (wait_q == 16'd0) && (!res_valid_q || res.ready);
	// a hold of zero behaves like a hold of one
	assign hold_load = (hold_cycles_q == 16'd0) ? 16'd0 : hold_cycles_q - 16'd1;

	always_comb begin
		case (cw.sda_sel)
			ibs_pkg::SDA_ONE:  sda_nxt = 1'b1;
			ibs_pkg::SDA_ZERO: sda_nxt = 1'b0;
			ibs_pkg::SDA_TX:   sda_nxt = tx_q[7];
			ibs_pkg::SDA_ACK:  sda_nxt = ack_q;
			default:           sda_nxt = sda_q;
		endcase
		case (cw.scl_sel)
			ibs_pkg::SCL_ONE:  scl_nxt = 1'b1;
			ibs_pkg::SCL_ZERO: scl_nxt = 1'b0;
			default:           scl_nxt = scl_q;
		endcase
		// read value shows only on the final step
		rv_nxt = 8'd0;
		if (step_last) begin
			case (cw.rv_sel)
				ibs_pkg::RV_BYTE: rv_nxt = bus_q;
				ibs_pkg::RV_ACK:  rv_nxt = {7'd0, bus_q[7]};
				default:          rv_nxt = 8'd0;
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles_q <= ibs_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			hold_cycles_q <= cfg_wdata;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			pc_q   <= ibs_pkg::PC_START;
			bit_q  <= 3'd0;
			wait_q <= 16'd0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else begin
			if (cmd_take && entry_ok) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				pc_q   <= entry_pc;
				bit_q  <= 3'd0;
				wait_q <= 16'd0;
			end else if (emit_go) begin
				scl_q  <= scl_nxt;
				sda_q  <= sda_nxt;
				pc_q   <= pc_nxt;
				fin_q  <= step_last;
				wait_q <= hold_load;
				if (loop_back) begin
					bit_q <= bit_q + 3'd1;
				end
			end else if (busy_q && wait_q != 16'd0) begin
				wait_q <= wait_q - 16'd1;
			end else if (busy_q && fin_q) begin
				// last line state has been held, free for the next command
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
			end
		end
	end

	// command payload, captured on acceptance
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			tx_q  <= cmd.tx_byte;
			ack_q <= cmd.ack_to_send;
			bus_q <= cmd.bus_sda_bits;
		end else if (emit_go && loop_back) begin
			tx_q <= {tx_q[6:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_scl_q  <= scl_nxt;
			res_sda_q  <= sda_nxt;
			res_rv_q   <= rv_nxt;
			res_last_q <= step_last;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.scl_level  = res_scl_q;
	assign res.sda_level  = res_sda_q;
	assign res.read_value = res_rv_q;
	assign res.last       = res_last_q;

endmodule

>>> sim/ibs_line_checker.sv
// line step checker for the i2c master bit sequencer: watches both channels
// depends on ibs_pkg (opcodes, hold reset value) and ibs_if.sv (channel interfaces)
module ibs_line_checker (
	input  logic        clk,
	input  logic        arst_n,
	ibs_cmd_if          cmd,
	ibs_res_if          res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] rd_val;
		logic       fin;
	} line_step_t;

	line_step_t  step_q[$];
	logic        scl_line;
	logic        sda_line;
	logic [15:0] hold_copy;

	// queue one line step with the current levels of both lines
	function automatic void push_step(input logic [7:0] rd_val, input logic fin);
		line_step_t s;
		s.scl    = scl_line;
		s.sda    = sda_line;
		s.rd_val = rd_val;
		s.fin    = fin;
		step_q.push_back(s);
	endfunction

	// expand one command into its line steps
	function automatic void expand_command(input logic [2:0] op, input logic [7:0] tx,
			input logic ack, input logic [7:0] bus);
		case (op)
			ibs_pkg::OP_START: begin
				sda_line = 1'b1; push_step(8'd0, 1'b0);
				scl_line = 1'b1; push_step(8'd0, 1'b0);
				sda_line = 1'b0; push_step(8'd0, 1'b0);
				scl_line = 1'b0; push_step(8'd0, 1'b1);
			end
			ibs_pkg::OP_STOP: begin
				sda_line = 1'b0; push_step(8'd0, 1'b0);
				scl_line = 1'b1; push_step(8'd0, 1'b0);
				sda_line = 1'b1; push_step(8'd0, 1'b1);
			end
			ibs_pkg::OP_WRITE: begin
				for (int i = 7; i >= 0; i--) begin
					sda_line = tx[i];  push_step(8'd0, 1'b0);
					scl_line = 1'b1;   push_step(8'd0, 1'b0);
					scl_line = 1'b0;   push_step(8'd0, i == 0);
				end
			end
			ibs_pkg::OP_READ: begin
				// the whole bus byte of the command comes back as the read value on the final step
				sda_line = 1'b1; push_step(8'd0, 1'b0);
				for (int i = 7; i >= 0; i--) begin
					scl_line = 1'b1; push_step(8'd0, 1'b0);
					scl_line = 1'b0; push_step((i == 0) ? bus : 8'd0, i == 0);
				end
			end
			ibs_pkg::OP_SACK: begin
				sda_line = ack;  push_step(8'd0, 1'b0);
				scl_line = 1'b1; push_step(8'd0, 1'b0);
				scl_line = 1'b0; push_step(8'd0, 1'b1);
			end
			ibs_pkg::OP_RACK: begin
				sda_line = 1'b1; push_step(8'd0, 1'b0);
				scl_line = 1'b1; push_step(8'd0, 1'b0);
				scl_line = 1'b0; push_step({7'd0, bus[7]}, 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		if (mismatches < 100)
			$display("%0t: line step mismatch on %s: expected %0h, got %0h (hold %0d)",
				$realtime, what, exp_val, got_val, hold_copy);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_step_t want;
		if (!arst_n) begin
			step_q.delete();
			scl_line   = 1'b1;
			sda_line   = 1'b1;
			hold_copy  = ibs_pkg::HOLD_RESET;
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg_we)
				hold_copy = cfg_wdata;
			if (res.valid && res.ready) begin
				if (step_q.size() == 0) begin
					report_mismatch("unexpected step", 0, 1);
				end else begin
					want = step_q.pop_front();
					if (res.scl_level !== want.scl)
						report_mismatch("scl_level", want.scl, res.scl_level);
					if (res.sda_level !== want.sda)
						report_mismatch("sda_level", want.sda, res.sda_level);
					if (res.read_value !== want.rd_val)
						report_mismatch("read_value", want.rd_val, res.read_value);
					if (res.last !== want.fin)
						report_mismatch("last", want.fin, res.last);
				end
			end
			if (cmd.valid && cmd.ready)
				expand_command(cmd.opcode, cmd.tx_byte, cmd.ack_to_send, cmd.bus_sda_bits);
			pending = step_q.size();
		end
	end

endmodule

>>> sim/tb_i2c_master_bit_sequencer_core.sv
// top of the i2c master bit sequencer testbench: clock, reset, command stimulus,
// receiver stalls, watchdog and verdict; depends on ibs_pkg, ibs_if.sv and ibs_line_checker
module tb_i2c_master_bit_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes the block takes and drops
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam int QUIET_LIMIT  = 300000;  // longest hold plus longest stall, several times over
	localparam int LONG_HOLDOFF = 400;     // receiver hold-off that backs the block up
	localparam int SETTLE       = 8;       // margin on top of one hold period before a write
	localparam int END_WAIT     = 50;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	ibs_cmd_if cmd_ch();
	ibs_res_if res_ch();

	int          mismatches;
	int          pending;
	int          quiet;
	int          cmds_sent;     // commands that cause steps, dropped opcodes not counted
	int          rx_stall;
	logic [15:0] cur_hold;
	bit          burst_mode;    // sender offers back to back
	logic        rx_free_run;   // receiver never stalls
	logic        holdoff_req;
	logic        holdoff_done;

	i2c_master_bit_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ibs_line_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// gap lengths: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, a free-running mode, and one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (holdoff_req && !holdoff_done) begin
			holdoff_done <= 1'b1;
			rx_stall     <= LONG_HOLDOFF;
			res_ch.ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall     <= rx_stall - 1;
			res_ch.ready <= 1'b0;
		end else if (rx_free_run || $urandom_range(0, 99) >= 20) begin
			res_ch.ready <= 1'b1;
		end else begin
			rx_stall     <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
			res_ch.ready <= 1'b0;
		end
	end

	// watchdog: cycles in a row with no item accepted on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// offer one command and wait until the block takes it; valid stays high on return
	task automatic send_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input logic [7:0] bus);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.opcode       <= op;
		cmd_ch.tx_byte      <= tx;
		cmd_ch.ack_to_send  <= ack;
		cmd_ch.bus_sda_bits <= bus;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		if (op != OP_RSVD_6 && op != OP_RSVD_7)
			cmds_sent++;
	endtask

	// stop offering and wait until every expected step is in and the block has gone idle
	task automatic drain();
		int settle;
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		// the last step may still be held, and a dropped opcode leaves nothing to wait on
		settle = ((cur_hold == 16'd0) ? 1 : int'(cur_hold)) + SETTLE;
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_hold(input logic [15:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_hold = val;
	endtask

	// a plausible bus transfer with random content; now and then the stop is left out
	task automatic run_transfer();
		int n_bytes;
		n_bytes = $urandom_range(1, 3);
		send_cmd(ibs_pkg::OP_START, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_RACK, 8'($urandom), 1'($urandom), 8'($urandom));
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				send_cmd(ibs_pkg::OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
				send_cmd(ibs_pkg::OP_RACK, 8'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				send_cmd(ibs_pkg::OP_READ, 8'($urandom), 1'($urandom), 8'($urandom));
				send_cmd(ibs_pkg::OP_SACK, 8'($urandom), 1'($urandom), 8'($urandom));
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_cmd(ibs_pkg::OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// mostly transfers, the rest single commands of any opcode
	task automatic run_random(input int n_items);
		int goal;
		goal = cmds_sent + n_items;
		while (cmds_sent < goal) begin
			if ($urandom_range(0, 3) == 0)
				send_cmd(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
			else
				run_transfer();
		end
	endtask

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 16'd0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = ibs_pkg::OP_START;
		cmd_ch.tx_byte      = 8'd0;
		cmd_ch.ack_to_send  = 1'b0;
		cmd_ch.bus_sda_bits = 8'd0;
		res_ch.ready        = 1'b0;
		quiet               = 0;
		cmds_sent           = 0;
		rx_stall            = 0;
		cur_hold            = ibs_pkg::HOLD_RESET;
		burst_mode          = 1'b0;
		rx_free_run         = 1'b0;
		holdoff_req         = 1'b0;
		holdoff_done        = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hold at its reset value: one start from released lines
		send_cmd(ibs_pkg::OP_START, 8'h3C, 1'b1, 8'hC3);

		// zero hold, directed: byte extremes, every opcode, dropped opcodes, repeated stop/start
		write_hold(16'd0);
		send_cmd(ibs_pkg::OP_START, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF);
		send_cmd(ibs_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00);
		send_cmd(ibs_pkg::OP_WRITE, 8'hA5, 1'b0, 8'h5A);
		send_cmd(ibs_pkg::OP_RACK, 8'h00, 1'b0, 8'h80);
		send_cmd(ibs_pkg::OP_RACK, 8'hFF, 1'b1, 8'h7F);
		send_cmd(ibs_pkg::OP_READ, 8'hFF, 1'b1, 8'h00);
		send_cmd(ibs_pkg::OP_READ, 8'h00, 1'b0, 8'hFF);
		send_cmd(ibs_pkg::OP_READ, 8'h96, 1'b1, 8'h5A);
		send_cmd(ibs_pkg::OP_SACK, 8'hFF, 1'b0, 8'hFF);
		send_cmd(ibs_pkg::OP_SACK, 8'h00, 1'b1, 8'h00);
		send_cmd(OP_RSVD_6, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(OP_RSVD_7, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_START, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_START, 8'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(ibs_pkg::OP_WRITE, 8'h5A, 1'b1, 8'hA5);
		send_cmd(ibs_pkg::OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom));

		// longest hold: a single stop keeps this phase short
		write_hold(16'hFFFF);
		send_cmd(ibs_pkg::OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom));

		// hold of one: the receiver holds off for a long stretch while commands keep coming
		write_hold(16'd1);
		burst_mode = 1'b1;
		holdoff_req <= 1'b1;
		run_random(12);
		burst_mode = 1'b0;
		run_random(40);

		write_hold(16'($urandom_range(2, 6)));
		run_random(50);

		write_hold(16'd0);
		run_random(50);

		// no idling on either side
		write_hold(16'd3);
		burst_mode = 1'b1;
		rx_free_run <= 1'b1;
		run_random(30);
		burst_mode = 1'b0;
		rx_free_run <= 1'b0;

		write_hold(ibs_pkg::HOLD_RESET);
		send_cmd(ibs_pkg::OP_SACK, 8'($urandom), 1'b0, 8'($urandom));

		// wait out every expected step, then a short quiet stretch for stray ones
		drain();
		repeat (END_WAIT) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
